[hdl/lbcs_pkg.sv]
// shared types, codes and reset constants of the led blink code sequencer
package lbcs_pkg;

	// widths fixed by the register and field formats
	localparam int unsigned CfgDataWidth  = 16;
	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned MsWidth       = 16;
	localparam int unsigned BlinkWidth    = 8;
	localparam int unsigned TimeWidthDef  = 16;

	// register indexes of the configuration port
	localparam logic [CfgIndexWidth-1:0] REG_START_TIME   = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_LONG_OFF     = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_OFF          = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_NORMAL_ON    = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_ERROR1_ON    = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_ERROR2_ON    = 3'd5;
	localparam logic [CfgIndexWidth-1:0] REG_ERROR1_BLINK = 3'd6;
	localparam logic [CfgIndexWidth-1:0] REG_ERROR2_BLINK = 3'd7;

	// register reset values
	localparam logic [MsWidth-1:0]    RstStartTime   = 16'd50;
	localparam logic [MsWidth-1:0]    RstLongOff     = 16'd1000;
	localparam logic [MsWidth-1:0]    RstOff         = 16'd100;
	localparam logic [MsWidth-1:0]    RstNormalOn    = 16'd0;
	localparam logic [MsWidth-1:0]    RstError1On    = 16'd100;
	localparam logic [MsWidth-1:0]    RstError2On    = 16'd100;
	localparam logic [BlinkWidth-1:0] RstError1Blink = 8'd2;
	localparam logic [BlinkWidth-1:0] RstError2Blink = 8'd1;
	localparam logic [BlinkWidth-1:0] NormalBlinks   = 8'd1;

	// request codes
	localparam logic [1:0] REQ_STEP = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_TEST = 2'd2;

	// mode codes
	localparam logic [1:0] MODE_ERROR1 = 2'd1;
	localparam logic [1:0] MODE_ERROR2 = 2'd2;

	typedef enum logic [1:0] {
		SP_IDLE    = 2'd0,
		SP_START   = 2'd1,
		SP_WAIT    = 2'd2,
		SP_OPERATE = 2'd3
	} start_phase_t;

	typedef enum logic [2:0] {
		BP_IDLE      = 3'd0,
		BP_LED_ON    = 3'd1,
		BP_ON_WAIT   = 3'd2,
		BP_OFF_WAIT  = 3'd3,
		BP_LONG_WAIT = 3'd4
	} blink_phase_t;

	// configuration register contents handed to the sequencer
	typedef struct packed {
		logic [MsWidth-1:0]    start_time_ms;
		logic [MsWidth-1:0]    long_off_ms;
		logic [MsWidth-1:0]    off_ms;
		logic [MsWidth-1:0]    normal_on_ms;
		logic [MsWidth-1:0]    error1_on_ms;
		logic [MsWidth-1:0]    error2_on_ms;
		logic [BlinkWidth-1:0] error1_blinks;
		logic [BlinkWidth-1:0] error2_blinks;
	} cfg_t;

	// result of one item, as it leaves the sequencer
	typedef struct packed {
		logic led_on;
		logic in_operate;
	} result_t;

endpackage

[hdl/lbcs_seq.sv]
// start-up and blink sequencer state with its next-state logic
module lbcs_seq #(
	parameter int unsigned TIME_WIDTH = lbcs_pkg::TimeWidthDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      req_type,
	input  logic [1:0]      mode,
	input  logic            test_level,
	input  lbcs_pkg::cfg_t  cfg,
	output lbcs_pkg::result_t result
);
	import lbcs_pkg::*;

	localparam logic [32:0] TimeMax = (33'd1 << TIME_WIDTH) - 33'd1;

	start_phase_t           start_phase_q, start_phase_d;
	blink_phase_t           blink_phase_q, blink_phase_d;
	logic [BlinkWidth-1:0]  blink_count_q, blink_count_d;
	logic [TIME_WIDTH-1:0]  time_left_q, time_left_d;
	logic                   time_over_q, time_over_d;
	logic                   test_mode_q, test_mode_d;
	logic                   led_level_q, led_level_d;

	logic [MsWidth-1:0]     on_time;
	logic [BlinkWidth-1:0]  blinks;
	logic [BlinkWidth-1:0]  count_inc;
	logic [MsWidth-1:0]     load_val;
	logic                   load_en;
	logic [32:0]            load_ext;
	logic [TIME_WIDTH-1:0]  load_sat;
	logic [TIME_WIDTH-1:0]  time_dec;

	// parameters of the mode carried by this step
	always_comb begin
		priority if (mode == MODE_ERROR1) begin
			on_time = cfg.error1_on_ms;
			blinks  = cfg.error1_blinks;
		end else if (mode == MODE_ERROR2) begin
			on_time = cfg.error2_on_ms;
			blinks  = cfg.error2_blinks;
		end else begin
			on_time = cfg.normal_on_ms;
			blinks  = NormalBlinks;
		end
	end

	assign count_inc = blink_count_q + BlinkWidth'(1);
	assign time_dec  = time_left_q - TIME_WIDTH'(1);

	// timer load saturates at the timer range
	assign load_ext = {{(33 - MsWidth){1'b0}}, load_val};
	assign load_sat = (load_ext > TimeMax) ? TimeMax[TIME_WIDTH-1:0]
	                                       : load_ext[TIME_WIDTH-1:0];

	// next state for the accepted item
	always_comb begin
		start_phase_d = start_phase_q;
		blink_phase_d = blink_phase_q;
		blink_count_d = blink_count_q;
		test_mode_d   = test_mode_q;
		led_level_d   = led_level_q;
		load_en       = 1'b0;
		load_val      = '0;

		if (req_type == REQ_STEP && !test_mode_q) begin
			unique case (start_phase_q)
				SP_IDLE: begin
					led_level_d   = 1'b1;
					start_phase_d = SP_START;
				end
				SP_START: begin
					led_level_d   = 1'b1;
					load_en       = 1'b1;
					load_val      = cfg.start_time_ms;
					start_phase_d = SP_WAIT;
				end
				SP_WAIT: begin
					if (time_over_q) begin
						led_level_d   = 1'b0;
						start_phase_d = SP_OPERATE;
					end
				end
				SP_OPERATE: begin
					unique case (blink_phase_q)
						BP_IDLE: begin
							led_level_d   = 1'b0;
							blink_phase_d = BP_LED_ON;
							blink_count_d = '0;
						end
						BP_LED_ON: begin
							// zero on time halts here, dark
							if (on_time != '0) begin
								led_level_d   = 1'b1;
								load_en       = 1'b1;
								load_val      = on_time;
								blink_phase_d = BP_ON_WAIT;
							end
						end
						BP_ON_WAIT: begin
							if (time_over_q && cfg.off_ms != '0) begin
								led_level_d   = 1'b0;
								load_en       = 1'b1;
								load_val      = cfg.off_ms;
								blink_phase_d = BP_OFF_WAIT;
							end
						end
						BP_OFF_WAIT: begin
							if (time_over_q) begin
								blink_count_d = count_inc;
								priority if (count_inc < blinks) begin
									blink_phase_d = BP_LED_ON;
								end else if (cfg.long_off_ms != '0) begin
									led_level_d   = 1'b0;
									load_en       = 1'b1;
									load_val      = cfg.long_off_ms;
									blink_phase_d = BP_LONG_WAIT;
								end else begin
									blink_phase_d = BP_IDLE;
								end
							end
						end
						BP_LONG_WAIT: begin
							if (time_over_q) begin
								blink_phase_d = BP_IDLE;
							end
						end
						default: begin
							blink_phase_d = BP_IDLE;
						end
					endcase
				end
			endcase
		end else if (req_type == REQ_TEST) begin
			test_mode_d = 1'b1;
			led_level_d = test_level;
		end
	end

	// shared timer: loads from steps, counts down on ticks
	always_comb begin
		time_left_d = time_left_q;
		time_over_d = time_over_q;
		if (load_en) begin
			time_left_d = load_sat;
			time_over_d = (load_sat == '0);
		end else if (req_type == REQ_TICK && time_left_q != '0) begin
			time_left_d = time_dec;
			time_over_d = (time_dec == '0);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_phase_q <= SP_IDLE;
			blink_phase_q <= BP_IDLE;
			blink_count_q <= '0;
			time_left_q   <= '0;
			time_over_q   <= 1'b0;
			test_mode_q   <= 1'b0;
			led_level_q   <= 1'b0;
		end else if (accept) begin
			start_phase_q <= start_phase_d;
			blink_phase_q <= blink_phase_d;
			blink_count_q <= blink_count_d;
			time_left_q   <= time_left_d;
			time_over_q   <= time_over_d;
			test_mode_q   <= test_mode_d;
			led_level_q   <= led_level_d;
		end
	end

	// result as seen after this item
	assign result.led_on     = led_level_d;
	assign result.in_operate = (start_phase_d == SP_OPERATE);

endmodule

[hdl/led_blink_code_sequencer.sv]
// top level of the led blink code sequencer: config registers, handshake, result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall  | req_type, mode, test_level
//  out     | output    | out_valid / out_stall| led_on, in_operate
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; its result is registered and appears in the cycle after accept.
// the sequencer state and timer update in the same cycle as the accept.
// in_stall rises only while a result is held and out_stall is high.
// reset clears the sequencer to start-up and the config registers to their defaults.
module led_blink_code_sequencer #(
	parameter int unsigned TIME_WIDTH = lbcs_pkg::TimeWidthDef
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic [1:0]                           mode,
	input  logic                                 test_level,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 led_on,
	output logic                                 in_operate,
	input  logic                                 cfg_wr_en,
	input  logic [lbcs_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [lbcs_pkg::CfgDataWidth-1:0]    cfg_data
);
	import lbcs_pkg::*;

	cfg_t    cfg_q;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time_ms <= RstStartTime;
			cfg_q.long_off_ms   <= RstLongOff;
			cfg_q.off_ms        <= RstOff;
			cfg_q.normal_on_ms  <= RstNormalOn;
			cfg_q.error1_on_ms  <= RstError1On;
			cfg_q.error2_on_ms  <= RstError2On;
			cfg_q.error1_blinks <= RstError1Blink;
			cfg_q.error2_blinks <= RstError2Blink;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_TIME:   cfg_q.start_time_ms <= cfg_data;
				REG_LONG_OFF:     cfg_q.long_off_ms   <= cfg_data;
				REG_OFF:          cfg_q.off_ms        <= cfg_data;
				REG_NORMAL_ON:    cfg_q.normal_on_ms  <= cfg_data;
				REG_ERROR1_ON:    cfg_q.error1_on_ms  <= cfg_data;
				REG_ERROR2_ON:    cfg_q.error2_on_ms  <= cfg_data;
				REG_ERROR1_BLINK: cfg_q.error1_blinks <= cfg_data[BlinkWidth-1:0];
				REG_ERROR2_BLINK: cfg_q.error2_blinks <= cfg_data[BlinkWidth-1:0];
			endcase
		end
	end

	// take an item unless a held result is blocked downstream
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	lbcs_seq #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.mode       (mode),
		.test_level (test_level),
		.cfg        (cfg_q),
		.result     (result)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_on     = result_q.led_on;
	assign in_operate = result_q.in_operate;

endmodule

[sim/led_blink_code_sequencer_tb.sv]
// self-checking testbench of the led blink code sequencer: directed table, random phases, test rows
module led_blink_code_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbcs_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 100;
	localparam int CLOSING_ITEMS = 40;

	// codes the package leaves unnamed
	localparam logic [1:0] REQ_NONE     = 2'd3;
	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam logic [1:0] MODE_INITIAL = 2'd3;

	// one row of the directed table: a register write or an item
	typedef struct {
		bit                       is_cfg;
		logic [CfgIndexWidth-1:0] reg_idx;
		logic [CfgDataWidth-1:0]  reg_val;
		logic [1:0]               req;
		logic [1:0]               mode_code;
		logic                     lvl;
		bit                       typed;
		result_t                  want;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               req_type;
	logic [1:0]               mode;
	logic                     test_level;
	logic                     out_valid;
	logic                     out_stall;
	logic                     led_on;
	logic                     in_operate;
	logic                     cfg_wr_en;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;

	// expectation typed into the table for the item now on the bus
	bit      row_typed;
	result_t row_expect;

	// led model: register copy and sequencer state
	cfg_t         regs;
	start_phase_t seq_phase;
	blink_phase_t blink_phase;
	logic [7:0]   blinks_done;
	logic [1:0]   shown_mode;
	logic [15:0]  ms_left;
	logic         ms_over;
	logic         frozen;
	logic         led_lvl;

	result_t   led_expected_q[$];
	int        mismatch_count;
	int        quiet_cycles;
	int        send_gap_pct;
	int        recv_gap_pct;
	logic [1:0] rand_mode;
	plan_row_t plan[$];
	int        first_test_row;

	led_blink_code_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.mode       (mode),
		.test_level (test_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.led_on     (led_on),
		.in_operate (in_operate),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// per-mode parameters, read live from the register copy; normal blinks come from the package constant
	function automatic logic [15:0] on_ms_for(input logic [1:0] m);
		if (m == MODE_ERROR1) return regs.error1_on_ms;
		if (m == MODE_ERROR2) return regs.error2_on_ms;
		return regs.normal_on_ms;
	endfunction

	function automatic logic [7:0] blinks_for(input logic [1:0] m);
		if (m == MODE_ERROR1) return regs.error1_blinks;
		if (m == MODE_ERROR2) return regs.error2_blinks;
		return NormalBlinks;
	endfunction

	task automatic load_ms(input logic [15:0] t);
		if (t == '0) begin
			ms_over = 1'b1;
			ms_left = '0;
		end else begin
			ms_left = t;
			ms_over = 1'b0;
		end
	endtask

	task automatic model_reset();
		regs.start_time_ms = RstStartTime;
		regs.long_off_ms   = RstLongOff;
		regs.off_ms        = RstOff;
		regs.normal_on_ms  = RstNormalOn;
		regs.error1_on_ms  = RstError1On;
		regs.error2_on_ms  = RstError2On;
		regs.error1_blinks = RstError1Blink;
		regs.error2_blinks = RstError2Blink;
		seq_phase   = SP_IDLE;
		blink_phase = BP_IDLE;
		blinks_done = '0;
		shown_mode  = MODE_INITIAL;
		ms_left     = '0;
		ms_over     = 1'b0;
		frozen      = 1'b0;
		led_lvl     = 1'b0;
	endtask

	// one step of the blink cycle once start-up is over
	task automatic blink_advance();
		case (blink_phase)
			BP_IDLE: begin
				led_lvl     = 1'b0;
				blink_phase = BP_LED_ON;
				blinks_done = '0;
			end
			BP_LED_ON: begin
				if (on_ms_for(shown_mode) != '0) begin
					led_lvl = 1'b1;
					load_ms(on_ms_for(shown_mode));
					blink_phase = BP_ON_WAIT;
				end
			end
			BP_ON_WAIT: begin
				if (ms_over && regs.off_ms != '0) begin
					led_lvl = 1'b0;
					load_ms(regs.off_ms);
					blink_phase = BP_OFF_WAIT;
				end
			end
			BP_OFF_WAIT: begin
				if (ms_over) begin
					blinks_done = blinks_done + 8'd1;
					if (blinks_done < blinks_for(shown_mode)) begin
						blink_phase = BP_LED_ON;
					end else if (regs.long_off_ms != '0) begin
						led_lvl = 1'b0;
						load_ms(regs.long_off_ms);
						blink_phase = BP_LONG_WAIT;
					end else begin
						blink_phase = BP_IDLE;
					end
				end
			end
			BP_LONG_WAIT: begin
				if (ms_over) blink_phase = BP_IDLE;
			end
			default: begin
				blink_phase = BP_IDLE;
			end
		endcase
	endtask

	// led level and operate flag after one accepted item
	task automatic predict_led(input logic [1:0] r, input logic [1:0] m, input logic l,
		output result_t res);
		case (r)
			REQ_STEP: begin
				if (!frozen) begin
					case (seq_phase)
						SP_IDLE: begin
							led_lvl   = 1'b1;
							seq_phase = SP_START;
						end
						SP_START: begin
							led_lvl = 1'b1;
							load_ms(regs.start_time_ms);
							seq_phase = SP_WAIT;
						end
						SP_WAIT: begin
							if (ms_over) begin
								led_lvl   = 1'b0;
								seq_phase = SP_OPERATE;
							end
						end
						default: begin
							shown_mode = m;
							blink_advance();
						end
					endcase
				end
			end
			REQ_TICK: begin
				if (ms_left != '0) begin
					ms_left = ms_left - 16'd1;
					ms_over = (ms_left == '0);
				end
			end
			REQ_TEST: begin
				frozen  = 1'b1;
				led_lvl = l;
			end
			default: ;
		endcase
		res.led_on     = led_lvl;
		res.in_operate = (seq_phase == SP_OPERATE);
	endtask

	// result check first, so a result never meets the item accepted at the same edge
	always @(posedge clk) begin
		result_t predicted;
		result_t oldest;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (led_expected_q.size() == 0) begin
					$display("%0t: result with no item waiting: led_on %b in_operate %b",
						$time, led_on, in_operate);
					mismatch_count++;
				end else begin
					oldest = led_expected_q.pop_front();
					if (led_on !== oldest.led_on) begin
						$display("%0t: led_on expected %b actual %b",
							$time, oldest.led_on, led_on);
						mismatch_count++;
					end
					if (in_operate !== oldest.in_operate) begin
						$display("%0t: in_operate expected %b actual %b",
							$time, oldest.in_operate, in_operate);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_led(req_type, mode, test_level, predicted);
				if (row_typed) predicted = row_expect;
				led_expected_q.push_back(predicted);
			end
		end
	end

	// cycles without any accepted item or result
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
		$display("led_blink_code_sequencer regression: fail");
		$finish;
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_gap_pct);
	end

	task automatic send_item(input logic [1:0] r, input logic [1:0] m, input logic l,
		input bit typed, input result_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = r;
		mode       = m;
		test_level = l;
		row_typed  = typed;
		row_expect = want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and wait until every result is back
	task automatic settle_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (led_expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
		input logic [CfgDataWidth-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_START_TIME:   regs.start_time_ms = val;
			REG_LONG_OFF:     regs.long_off_ms   = val;
			REG_OFF:          regs.off_ms        = val;
			REG_NORMAL_ON:    regs.normal_on_ms  = val;
			REG_ERROR1_ON:    regs.error1_on_ms  = val;
			REG_ERROR2_ON:    regs.error2_on_ms  = val;
			REG_ERROR1_BLINK: regs.error1_blinks = val[7:0];
			REG_ERROR2_BLINK: regs.error2_blinks = val[7:0];
			default: ;
		endcase
	endtask

	function automatic plan_row_t cfg_row(input logic [CfgIndexWidth-1:0] idx,
		input logic [CfgDataWidth-1:0] val);
		plan_row_t row;
		row.is_cfg    = 1'b1;
		row.reg_idx   = idx;
		row.reg_val   = val;
		row.req       = REQ_NONE;
		row.mode_code = MODE_NORMAL;
		row.lvl       = 1'b0;
		row.typed     = 1'b0;
		row.want      = '0;
		return row;
	endfunction

	function automatic plan_row_t checked_row(input logic [1:0] r, input logic [1:0] m,
		input logic l, input bit typed, input logic led, input logic op);
		plan_row_t row;
		row.is_cfg          = 1'b0;
		row.reg_idx         = REG_START_TIME;
		row.reg_val         = '0;
		row.req             = r;
		row.mode_code       = m;
		row.lvl             = l;
		row.typed           = typed;
		row.want.led_on     = led;
		row.want.in_operate = op;
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic [1:0] r, input logic [1:0] m,
		input logic l);
		return checked_row(r, m, l, 1'b0, 1'b0, 1'b0);
	endfunction

	task automatic run_row(input plan_row_t row);
		if (row.is_cfg) begin
			settle_idle();
			write_reg(row.reg_idx, row.reg_val);
		end else begin
			send_item(row.req, row.mode_code, row.lvl, row.typed, row.want);
		end
	endtask

	// register set of one random phase: small times mostly, extremes in three phases
	task automatic load_phase_setting(input int p);
		logic [15:0] t[6];
		logic [7:0]  b[2];
		int          i;
		for (i = 0; i < 6; i++) begin
			if (p == 3)      t[i] = 16'hFFFF;
			else if (p == 7) t[i] = 16'h0000;
			else             t[i] = 16'($urandom_range(0, 4));
		end
		for (i = 0; i < 2; i++) begin
			if (p == 3 || p == 10) b[i] = 8'hFF;
			else if (p == 7)       b[i] = 8'h00;
			else                   b[i] = 8'($urandom_range(0, 4));
		end
		if (p == 10) begin
			t[2] = 16'd1;
			t[4] = 16'd1;
		end
		write_reg(REG_START_TIME,   t[0]);
		write_reg(REG_LONG_OFF,     t[1]);
		write_reg(REG_OFF,          t[2]);
		write_reg(REG_NORMAL_ON,    t[3]);
		write_reg(REG_ERROR1_ON,    t[4]);
		write_reg(REG_ERROR2_ON,    t[5]);
		write_reg(REG_ERROR1_BLINK, {8'h00, b[0]});
		write_reg(REG_ERROR2_BLINK, {8'h00, b[1]});
	endtask

	// random item: steps and ticks mostly, mode sticky with occasional changes
	task automatic send_random(input bit allow_test);
		int         pick;
		logic [1:0] r;
		pick = $urandom_range(0, 99);
		if (allow_test && pick >= 90) r = REQ_TEST;
		else if (pick < 48)           r = REQ_STEP;
		else if (pick < 95)           r = REQ_TICK;
		else                          r = REQ_NONE;
		if ($urandom_range(0, 99) < 8) rand_mode = 2'($urandom_range(0, 3));
		send_item(r, rand_mode, 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	initial begin
		int k;
		int p;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_NONE;
		mode           = MODE_NORMAL;
		test_level     = 1'b0;
		out_stall      = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = REG_START_TIME;
		cfg_data       = '0;
		row_typed      = 1'b0;
		row_expect     = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		send_gap_pct   = 26;
		recv_gap_pct   = 54;
		rand_mode      = MODE_ERROR1;
		model_reset();

		// start-up with a zero flash, then the blink special cases
		plan.push_back(checked_row(REQ_TICK, MODE_NORMAL, 1'b0, 1'b1, 1'b0, 1'b0));
		plan.push_back(checked_row(REQ_NONE, MODE_SPARE, 1'b1, 1'b1, 1'b0, 1'b0));
		plan.push_back(cfg_row(REG_START_TIME, 16'd0));
		plan.push_back(checked_row(REQ_STEP, MODE_NORMAL, 1'b0, 1'b1, 1'b1, 1'b0));
		plan.push_back(checked_row(REQ_STEP, MODE_NORMAL, 1'b0, 1'b1, 1'b1, 1'b0));
		plan.push_back(checked_row(REQ_STEP, MODE_NORMAL, 1'b0, 1'b1, 1'b0, 1'b1));
		// normal mode with zero on time stays dark; spare mode code acts as normal
		plan.push_back(item_row(REQ_STEP, MODE_NORMAL, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_SPARE, 1'b1));
		// zero off time halts lit, zero blinks and zero long off restart the group
		plan.push_back(cfg_row(REG_ERROR1_ON, 16'd1));
		plan.push_back(cfg_row(REG_OFF, 16'd0));
		plan.push_back(cfg_row(REG_LONG_OFF, 16'd0));
		plan.push_back(cfg_row(REG_ERROR1_BLINK, 16'd0));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_TICK, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(cfg_row(REG_OFF, 16'd1));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_TICK, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR2, 1'b0));
		// mode change mid-blink with widest registers
		plan.push_back(cfg_row(REG_NORMAL_ON, 16'hFFFF));
		plan.push_back(cfg_row(REG_ERROR2_BLINK, 16'h00FF));
		plan.push_back(cfg_row(REG_LONG_OFF, 16'hFFFF));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR2, 1'b0));
		plan.push_back(item_row(REQ_STEP, MODE_NORMAL, 1'b0));
		plan.push_back(item_row(REQ_TICK, MODE_NORMAL, 1'b0));
		// test commands freeze the sequencer, so they close the run
		first_test_row = plan.size();
		plan.push_back(checked_row(REQ_TEST, MODE_NORMAL, 1'b1, 1'b1, 1'b1, 1'b1));
		plan.push_back(item_row(REQ_STEP, MODE_ERROR1, 1'b0));
		plan.push_back(item_row(REQ_TICK, MODE_NORMAL, 1'b1));
		plan.push_back(checked_row(REQ_TEST, MODE_SPARE, 1'b0, 1'b1, 1'b0, 1'b1));
		plan.push_back(item_row(REQ_NONE, MODE_ERROR2, 1'b1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < first_test_row; k++) run_row(plan[k]);
		settle_idle();

		// random phases, each under a fresh register set
		for (p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				send_gap_pct = 26;
				recv_gap_pct = 54;
			end else if (p < 8) begin
				send_gap_pct = 54;
				recv_gap_pct = 26;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			load_phase_setting(p);
			repeat (PHASE_ITEMS) send_random(1'b0);
			settle_idle();
		end

		for (k = first_test_row; k < plan.size(); k++) run_row(plan[k]);
		repeat (CLOSING_ITEMS) send_random(1'b1);
		settle_idle();
		repeat (4) @(posedge clk);

		if (mismatch_count == 0)
			$display("led_blink_code_sequencer regression: pass");
		else
			$display("led_blink_code_sequencer regression: fail");
		$finish;
	end

endmodule

[led_blink_code_sequencer.f]
hdl/lbcs_pkg.sv
hdl/lbcs_seq.sv
hdl/led_blink_code_sequencer.sv
sim/led_blink_code_sequencer_tb.sv
